// File: design/qrs_pkg.sv
package qrs_pkg;

   localparam int COEFF_WIDTH = 16;
   localparam int FRAC_BITS   = 16;
   localparam int ROOT_WIDTH  = COEFF_WIDTH + FRAC_BITS + 2;

   localparam int PROD_WIDTH  = 2 * COEFF_WIDTH;
   localparam int DISC_WIDTH  = 2 * COEFF_WIDTH + 3;
   localparam int DIN_WIDTH   = 2 * (COEFF_WIDTH + 1);
   localparam int SQRT_PAIRS  = COEFF_WIDTH + 1 + FRAC_BITS;
   localparam int SQRT_WIDTH  = SQRT_PAIRS;
   localparam int SREM_WIDTH  = SQRT_WIDTH + 3;
   localparam int NUM_SWIDTH  = ROOT_WIDTH + 1;
   localparam int DEN_WIDTH   = COEFF_WIDTH + 1;
   localparam int DREM_WIDTH  = DEN_WIDTH + 1;

   typedef logic signed [COEFF_WIDTH-1:0] coeff_type;
   typedef logic signed [ROOT_WIDTH-1:0]  root_type;

   typedef struct packed {
      logic      flag;
      coeff_type a;
      coeff_type b;
   } side_type;

   typedef struct packed {
      logic flag;
      logic neg;
   } div_tag_type;

endpackage

// File: design/qrs_req_if.sv
interface qrs_req_if;
   logic               valid;
   logic               ready;
   qrs_pkg::coeff_type coeff_a;
   qrs_pkg::coeff_type coeff_b;
   qrs_pkg::coeff_type coeff_c;

   modport source (output valid, output coeff_a, output coeff_b, output coeff_c, input ready);
   modport sink   (input valid, input coeff_a, input coeff_b, input coeff_c, output ready);
endinterface

// File: design/qrs_rsp_if.sv
interface qrs_rsp_if;
   logic              valid;
   logic              ready;
   logic              has_real_roots;
   qrs_pkg::root_type root_plus;
   qrs_pkg::root_type root_minus;

   modport source (output valid, output has_real_roots, output root_plus,
                   output root_minus, input ready);
   modport sink   (input valid, input has_real_roots, input root_plus,
                   input root_minus, output ready);
endinterface

// File: design/qrs_disc.sv
module qrs_disc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  qrs_pkg::coeff_type                in_a,
   input  qrs_pkg::coeff_type                in_b,
   input  qrs_pkg::coeff_type                in_c,
   output logic                              out_valid,
   output qrs_pkg::side_type                 out_side,
   output logic [qrs_pkg::DIN_WIDTH-1:0]     out_d
);

   logic                                   p_valid_ff;
   qrs_pkg::coeff_type                     p_a_ff, p_b_ff;
   logic signed [qrs_pkg::PROD_WIDTH-1:0]  bb_ff, bb_in;
   logic signed [qrs_pkg::PROD_WIDTH-1:0]  ac_ff, ac_in;
   logic signed [qrs_pkg::DISC_WIDTH-1:0]  disc;
   logic                                   d_valid_ff;
   qrs_pkg::side_type                      d_side_ff, d_side_in;
   logic [qrs_pkg::DIN_WIDTH-1:0]          d_ff, d_in;

   assign bb_in = in_b * in_b;
   assign ac_in = in_a * in_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (enable) begin
         p_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_a_ff <= in_a;
         p_b_ff <= in_b;
         bb_ff  <= bb_in;
         ac_ff  <= ac_in;
      end
   end

   always_comb begin
      disc = qrs_pkg::DISC_WIDTH'(bb_ff) - (qrs_pkg::DISC_WIDTH'(ac_ff) <<< 2);
      d_side_in.flag = !disc[qrs_pkg::DISC_WIDTH-1] && (p_a_ff != '0);
      d_side_in.a    = p_a_ff;
      d_side_in.b    = p_b_ff;
      d_in           = disc[qrs_pkg::DIN_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (enable) begin
         d_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d_side_ff <= d_side_in;
         d_ff      <= d_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_side  = d_side_ff;
   assign out_d     = d_ff;

endmodule

// File: design/qrs_sqrt.sv
module qrs_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               in_valid,
   input  qrs_pkg::side_type                  in_side,
   input  logic [qrs_pkg::DIN_WIDTH-1:0]      in_d,
   output logic                               out_valid,
   output qrs_pkg::side_type                  out_side,
   output logic [qrs_pkg::SQRT_WIDTH-1:0]     out_root
);

   localparam int N = qrs_pkg::SQRT_PAIRS;

   logic                               valid_ff [N];
   qrs_pkg::side_type                  side_ff  [N];
   logic [qrs_pkg::DIN_WIDTH-1:0]      d_ff     [N];
   logic [qrs_pkg::SREM_WIDTH-1:0]     rem_ff   [N];
   logic [qrs_pkg::SQRT_WIDTH-1:0]     root_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam int I = N - 1 - k;

      logic                               prev_valid;
      qrs_pkg::side_type                  prev_side;
      logic [qrs_pkg::DIN_WIDTH-1:0]      prev_d;
      logic [qrs_pkg::SREM_WIDTH-1:0]     prev_rem;
      logic [qrs_pkg::SQRT_WIDTH-1:0]     prev_root;
      logic [1:0]                         pair;
      logic [qrs_pkg::SREM_WIDTH-1:0]     shifted;
      logic [qrs_pkg::SREM_WIDTH-1:0]     trial;
      logic [qrs_pkg::SREM_WIDTH-1:0]     rem_in;
      logic [qrs_pkg::SQRT_WIDTH-1:0]     root_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_side  = in_side;
         assign prev_d     = in_d;
         assign prev_rem   = '0;
         assign prev_root  = '0;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_side  = side_ff[k-1];
         assign prev_d     = d_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_root  = root_ff[k-1];
      end

      if (I >= qrs_pkg::FRAC_BITS) begin : g_pair
         assign pair = prev_d[2*(I-qrs_pkg::FRAC_BITS)+1 -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      always_comb begin
         shifted = {prev_rem[qrs_pkg::SREM_WIDTH-3:0], pair};
         trial   = qrs_pkg::SREM_WIDTH'({prev_root, 2'b01});
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {prev_root[qrs_pkg::SQRT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {prev_root[qrs_pkg::SQRT_WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[k] <= prev_side;
            d_ff[k]    <= prev_d;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_side  = side_ff[N-1];
   assign out_root  = root_ff[N-1];

endmodule

// File: design/qrs_div.sv
module qrs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  qrs_pkg::div_tag_type              in_tag,
   input  logic [qrs_pkg::ROOT_WIDTH-1:0]    in_num,
   input  logic [qrs_pkg::DEN_WIDTH-1:0]     in_den,
   output logic                              out_valid,
   output qrs_pkg::div_tag_type              out_tag,
   output logic [qrs_pkg::ROOT_WIDTH-1:0]    out_quo
);

   localparam int N = qrs_pkg::ROOT_WIDTH;

   logic                               valid_ff [N];
   qrs_pkg::div_tag_type               tag_ff   [N];
   logic [qrs_pkg::ROOT_WIDTH-1:0]     num_ff   [N];
   logic [qrs_pkg::DEN_WIDTH-1:0]      den_ff   [N];
   logic [qrs_pkg::DREM_WIDTH-1:0]     rem_ff   [N];
   logic [qrs_pkg::ROOT_WIDTH-1:0]     quo_ff   [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                               prev_valid;
      qrs_pkg::div_tag_type               prev_tag;
      logic [qrs_pkg::ROOT_WIDTH-1:0]     prev_num;
      logic [qrs_pkg::DEN_WIDTH-1:0]      prev_den;
      logic [qrs_pkg::DREM_WIDTH-1:0]     prev_rem;
      logic [qrs_pkg::ROOT_WIDTH-1:0]     prev_quo;
      logic [qrs_pkg::DREM_WIDTH-1:0]     shifted;
      logic [qrs_pkg::DREM_WIDTH-1:0]     rem_in;
      logic [qrs_pkg::ROOT_WIDTH-1:0]     quo_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_tag   = in_tag;
         assign prev_num   = in_num;
         assign prev_den   = in_den;
         assign prev_rem   = '0;
         assign prev_quo   = '0;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_tag   = tag_ff[k-1];
         assign prev_num   = num_ff[k-1];
         assign prev_den   = den_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_quo   = quo_ff[k-1];
      end

      always_comb begin
         shifted = {prev_rem[qrs_pkg::DREM_WIDTH-2:0], prev_num[N-1-k]};
         if (shifted >= {1'b0, prev_den}) begin
            rem_in = shifted - {1'b0, prev_den};
            quo_in = {prev_quo[N-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {prev_quo[N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            tag_ff[k] <= prev_tag;
            num_ff[k] <= prev_num;
            den_ff[k] <= prev_den;
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_tag   = tag_ff[N-1];
   assign out_quo   = quo_ff[N-1];

endmodule

// File: design/quadratic_root_solver.sv
// Solves a*x^2 + b*x + c = 0 for one set of 16-bit signed coefficients per
// transfer and returns both real roots in signed Q17.16, or a clear flag and
// zero roots when the discriminant is negative or a is zero. The block is a
// fully pipelined datapath that takes a new transfer every cycle while the
// result side does not stall, and passes each transfer through 71 register
// stages: two for the discriminant, 33 for the square root (one result bit
// each), one to form the numerators, 34 for the two parallel dividers (one
// quotient bit each) and the output register. When the result side stalls,
// the whole pipeline holds and no new transfer is taken.
module quadratic_root_solver (
   input  logic        clock,
   input  logic        reset,
   qrs_req_if.sink     req_port,
   qrs_rsp_if.source   rsp_port
);

   logic                                   enable;
   logic                                   disc_valid;
   qrs_pkg::side_type                      disc_side;
   logic [qrs_pkg::DIN_WIDTH-1:0]          disc_d;
   logic                                   sq_valid;
   qrs_pkg::side_type                      sq_side;
   logic [qrs_pkg::SQRT_WIDTH-1:0]         sq_root;

   logic signed [qrs_pkg::NUM_SWIDTH-1:0]  nb, np, nm, s_ext;
   logic signed [qrs_pkg::DEN_WIDTH-1:0]   a_ext, a_mag;
   logic                                   n_valid_ff;
   qrs_pkg::div_tag_type                   tp_ff, tp_in, tm_ff, tm_in;
   logic [qrs_pkg::ROOT_WIDTH-1:0]         np_ff, np_in, nm_ff, nm_in;
   logic [qrs_pkg::DEN_WIDTH-1:0]          den_ff, den_in;

   logic                                   dp_valid, dm_valid;
   qrs_pkg::div_tag_type                   dp_tag, dm_tag;
   logic [qrs_pkg::ROOT_WIDTH-1:0]         dp_quo, dm_quo;

   logic                                   rsp_valid_ff;
   logic                                   flag_ff;
   qrs_pkg::root_type                      rp_ff, rp_in, rm_ff, rm_in;

   assign enable         = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = enable;

   qrs_disc u_disc (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_port.valid),
      .in_a      (req_port.coeff_a),
      .in_b      (req_port.coeff_b),
      .in_c      (req_port.coeff_c),
      .out_valid (disc_valid),
      .out_side  (disc_side),
      .out_d     (disc_d)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (disc_valid),
      .in_side   (disc_side),
      .in_d      (disc_d),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   always_comb begin
      nb    = -(qrs_pkg::NUM_SWIDTH'(sq_side.b) <<< qrs_pkg::FRAC_BITS);
      s_ext = $signed(qrs_pkg::NUM_SWIDTH'(sq_root));
      np    = nb + s_ext;
      nm    = nb - s_ext;
      a_ext = qrs_pkg::DEN_WIDTH'(sq_side.a);
      a_mag = a_ext[qrs_pkg::DEN_WIDTH-1] ? -a_ext : a_ext;
      den_in = {a_mag[qrs_pkg::DEN_WIDTH-2:0], 1'b0};
      np_in = np[qrs_pkg::NUM_SWIDTH-1] ? qrs_pkg::ROOT_WIDTH'(-np)
                                        : qrs_pkg::ROOT_WIDTH'(np);
      nm_in = nm[qrs_pkg::NUM_SWIDTH-1] ? qrs_pkg::ROOT_WIDTH'(-nm)
                                        : qrs_pkg::ROOT_WIDTH'(nm);
      tp_in.flag = sq_side.flag;
      tp_in.neg  = np[qrs_pkg::NUM_SWIDTH-1] ^ sq_side.a[qrs_pkg::COEFF_WIDTH-1];
      tm_in.flag = sq_side.flag;
      tm_in.neg  = nm[qrs_pkg::NUM_SWIDTH-1] ^ sq_side.a[qrs_pkg::COEFF_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (enable) begin
         n_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tp_ff  <= tp_in;
         tm_ff  <= tm_in;
         np_ff  <= np_in;
         nm_ff  <= nm_in;
         den_ff <= den_in;
      end
   end

   qrs_div u_div_plus (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (n_valid_ff),
      .in_tag    (tp_ff),
      .in_num    (np_ff),
      .in_den    (den_ff),
      .out_valid (dp_valid),
      .out_tag   (dp_tag),
      .out_quo   (dp_quo)
   );

   qrs_div u_div_minus (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (n_valid_ff),
      .in_tag    (tm_ff),
      .in_num    (nm_ff),
      .in_den    (den_ff),
      .out_valid (dm_valid),
      .out_tag   (dm_tag),
      .out_quo   (dm_quo)
   );

   always_comb begin
      if (!dp_tag.flag) begin
         rp_in = '0;
      end else if (dp_tag.neg) begin
         rp_in = -$signed(dp_quo);
      end else begin
         rp_in = $signed(dp_quo);
      end
      if (!dm_tag.flag) begin
         rm_in = '0;
      end else if (dm_tag.neg) begin
         rm_in = -$signed(dm_quo);
      end else begin
         rm_in = $signed(dm_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         flag_ff <= dp_tag.flag;
         rp_ff   <= rp_in;
         rm_ff   <= rm_in;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.has_real_roots = flag_ff;
   assign rsp_port.root_plus      = rp_ff;
   assign rsp_port.root_minus     = rm_ff;

   a_no_roots_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !flag_ff |-> (rp_ff == '0) && (rm_ff == '0))
      else $error("A result without real roots carries a nonzero root.");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (dp_valid == dm_valid) && (!dp_valid || (dp_tag.flag == dm_tag.flag)))
      else $error("The two dividers have fallen out of step.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !n_valid_ff)
      else $error("The pipeline holds a result after reset.");

endmodule
